FILE: rtl/ipv4enc_pkg.sv
`default_nettype none

package ipv4enc_pkg;

    localparam int unsigned MAX_PAYLOAD = 1472;
    localparam int unsigned LEN_W       = 11;
    localparam int unsigned IDX_W       = 6;
    localparam int unsigned HDR_LEN     = 34;
    localparam int unsigned IP_HDR_LEN  = 20;

    localparam logic [IDX_W-1:0] HDR_LAST = IDX_W'(HDR_LEN - 1);
    localparam logic [LEN_W-1:0] LEN_MAX  = LEN_W'(MAX_PAYLOAD);

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_DEST_MAC   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_MAC = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE_IP  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEST_IP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOP_LIMIT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PROTOCOL   = 3'd5;

    localparam logic [47:0] DEST_MAC_RST   = 48'hffff_ffff_ffff;
    localparam logic [47:0] SOURCE_MAC_RST = 48'h0000_0033_3333;
    localparam logic [31:0] SOURCE_IP_RST  = 32'hc0a8_ff01;
    localparam logic [31:0] DEST_IP_RST    = 32'hc0a8_ff0a;
    localparam logic [7:0]  HOP_LIMIT_RST  = 8'd50;
    localparam logic [7:0]  PROTOCOL_RST   = 8'hff;

    localparam logic [7:0]  ETHTYPE_HI = 8'h08;
    localparam logic [7:0]  ETHTYPE_LO = 8'h00;
    localparam logic [7:0]  VER_IHL    = 8'h45;

    typedef enum logic
    {
        OP_START   = 1'b0,
        OP_PAYLOAD = 1'b1
    } op_t;

    typedef struct packed
    {
        logic [47:0] dest_mac;
        logic [47:0] source_mac;
        logic [31:0] source_ip;
        logic [31:0] dest_ip;
        logic [7:0]  hop_limit;
        logic [7:0]  protocol_number;
    } cfg_t;

endpackage

`default_nettype wire

FILE: rtl/ipv4_ethernet_encapsulator_top.sv
// Accepted items sit in the item registers; output bytes are registered before m_axis.
// A payload item gives one output byte; a start item gives its 34 header bytes one by one
// from the header byte counter. A new item is taken as the current one retires.
// A payload item with no frame open retires and gives no output.
// Reset (rst_n low, asynchronous): registers to defaults, no frame open, pipeline empty.
`default_nettype none

module ipv4_ethernet_encapsulator_top
    import ipv4enc_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [23:0]           s_axis_tdata,  // payload_length[10:0], data_byte[18:11]
    input  wire logic                  s_axis_tuser,  // op
    input  wire logic                  s_axis_tlast,  // end_of_payload

    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [7:0]                 m_axis_tdata,  // out_byte[7:0]
    output logic [1:0]                 m_axis_tuser,  // header_byte[0], run_end[1]
    output logic                       m_axis_tlast   // frame_end
);

    cfg_t cfg_reg;

    logic             cur_valid_reg;
    op_t              cur_op_reg;
    logic [LEN_W-1:0] cur_len_reg;
    logic [7:0]       cur_byte_reg;
    logic             cur_eop_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             frame_open_reg;

    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_hdr_reg;
    logic             out_fend_reg;
    logic             out_rend_reg;

    logic             s_accept;
    logic [LEN_W-1:0] in_len_sat;
    logic             out_free;
    logic             emit;
    logic             hdr_last;
    logic             cur_done;
    logic [7:0]       hdr_byte;

    assign in_len_sat = (s_axis_tdata[10:0] > LEN_MAX) ? LEN_MAX : s_axis_tdata[10:0];

    assign out_free = !out_valid_reg || m_axis_tready;
    assign hdr_last = (idx_reg == HDR_LAST);
    assign emit     = cur_valid_reg && out_free &&
                      ((cur_op_reg == OP_START) || frame_open_reg);
    // a stray payload item retires without touching the output side
    assign cur_done = cur_valid_reg &&
                      (((cur_op_reg == OP_PAYLOAD) && !frame_open_reg) ||
                       (emit && ((cur_op_reg == OP_PAYLOAD) || hdr_last)));

    assign s_axis_tready = !cur_valid_reg || cur_done;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    assign idx_next = hdr_last ? '0 : idx_reg + IDX_W'(1);

    ipv4enc_hdr u_hdr
    (
        .clk      (clk),
        .cfg      (cfg_reg),
        .len      (cur_len_reg),
        .idx      (idx_reg),
        .hdr_byte (hdr_byte)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dest_mac        <= DEST_MAC_RST;
            cfg_reg.source_mac      <= SOURCE_MAC_RST;
            cfg_reg.source_ip       <= SOURCE_IP_RST;
            cfg_reg.dest_ip         <= DEST_IP_RST;
            cfg_reg.hop_limit       <= HOP_LIMIT_RST;
            cfg_reg.protocol_number <= PROTOCOL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEST_MAC:   cfg_reg.dest_mac        <= cfg_data;
                REG_SOURCE_MAC: cfg_reg.source_mac      <= cfg_data;
                REG_SOURCE_IP:  cfg_reg.source_ip       <= cfg_data[31:0];
                REG_DEST_IP:    cfg_reg.dest_ip         <= cfg_data[31:0];
                REG_HOP_LIMIT:  cfg_reg.hop_limit       <= cfg_data[7:0];
                REG_PROTOCOL:   cfg_reg.protocol_number <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg  <= 1'b0;
            idx_reg        <= '0;
            frame_open_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_accept)
                cur_valid_reg <= 1'b1;
            else if (cur_done)
                cur_valid_reg <= 1'b0;

            if (emit && (cur_op_reg == OP_START))
                idx_reg <= idx_next;

            if (cur_done)
            begin
                if (cur_op_reg == OP_START)
                    frame_open_reg <= (cur_len_reg != '0);
                else if (frame_open_reg && cur_eop_reg)
                    frame_open_reg <= 1'b0;
            end

            if (out_free)
                out_valid_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            cur_op_reg   <= op_t'(s_axis_tuser);
            cur_len_reg  <= in_len_sat;
            cur_byte_reg <= s_axis_tdata[18:11];
            cur_eop_reg  <= s_axis_tlast;
        end

        if (emit)
        begin
            if (cur_op_reg == OP_START)
            begin
                out_byte_reg <= hdr_byte;
                out_hdr_reg  <= 1'b1;
                out_fend_reg <= hdr_last && (cur_len_reg == '0);
                out_rend_reg <= hdr_last;
            end
            else
            begin
                out_byte_reg <= cur_byte_reg;
                out_hdr_reg  <= 1'b0;
                out_fend_reg <= cur_eop_reg;
                out_rend_reg <= 1'b1;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_byte_reg;
    assign m_axis_tuser  = {out_rend_reg, out_hdr_reg};
    assign m_axis_tlast  = out_fend_reg;

    // header counter never leaves the header
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_reg <= HDR_LAST)
        else $error("header byte counter out of range");

    // the last header byte returns the counter to the first
    a_idx_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (cur_op_reg == OP_START) && hdr_last) |=> (idx_reg == '0))
        else $error("header byte counter did not wrap");

    // the closing payload item closes the frame
    a_frame_close: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (cur_op_reg == OP_PAYLOAD) && cur_eop_reg) |=> !frame_open_reg)
        else $error("frame left open after last payload item");

    // a header item only ends the frame on its last byte
    a_hdr_end: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (cur_op_reg == OP_START) && !hdr_last) |=> !(m_axis_tlast && m_axis_tuser[0]))
        else $error("frame end flagged inside header");

endmodule

`default_nettype wire

FILE: rtl/ipv4enc_hdr.sv
`default_nettype none

module ipv4enc_hdr
    import ipv4enc_pkg::*;
(
    input  wire logic             clk,
    input  wire cfg_t             cfg,
    input  wire logic [LEN_W-1:0] len,
    input  wire logic [IDX_W-1:0] idx,
    output logic      [7:0]       hdr_byte
);

    logic [15:0] total;
    logic [18:0] base_sum_next;
    logic [18:0] base_sum_reg;
    logic [18:0] sum_next;
    logic [18:0] sum_reg;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [15:0] ck_reg;

    assign total = 16'({5'd0, len}) + 16'(IP_HDR_LEN);

    // header words that do not depend on the length
    assign base_sum_next = 19'({VER_IHL, 8'h00})
                         + 19'({cfg.hop_limit, cfg.protocol_number})
                         + 19'(cfg.source_ip[31:16]) + 19'(cfg.source_ip[15:0])
                         + 19'(cfg.dest_ip[31:16])   + 19'(cfg.dest_ip[15:0]);

    assign sum_next = sum_reg;
    // two end-around folds are enough for a 19-bit sum
    assign fold1 = 17'(sum_next[15:0]) + 17'(sum_next[18:16]);
    assign fold2 = fold1[15:0] + 16'(fold1[16]);

    // the length holds for the whole header, so the checksum settles long before byte 24
    always_ff @(posedge clk)
    begin
        base_sum_reg <= base_sum_next;
        sum_reg      <= base_sum_reg + 19'(total);
        ck_reg       <= ~fold2;
    end

    always_comb
    begin
        unique case (idx)
            6'd0:    hdr_byte = cfg.dest_mac[47:40];
            6'd1:    hdr_byte = cfg.dest_mac[39:32];
            6'd2:    hdr_byte = cfg.dest_mac[31:24];
            6'd3:    hdr_byte = cfg.dest_mac[23:16];
            6'd4:    hdr_byte = cfg.dest_mac[15:8];
            6'd5:    hdr_byte = cfg.dest_mac[7:0];
            6'd6:    hdr_byte = cfg.source_mac[47:40];
            6'd7:    hdr_byte = cfg.source_mac[39:32];
            6'd8:    hdr_byte = cfg.source_mac[31:24];
            6'd9:    hdr_byte = cfg.source_mac[23:16];
            6'd10:   hdr_byte = cfg.source_mac[15:8];
            6'd11:   hdr_byte = cfg.source_mac[7:0];
            6'd12:   hdr_byte = ETHTYPE_HI;
            6'd13:   hdr_byte = ETHTYPE_LO;
            6'd14:   hdr_byte = VER_IHL;
            6'd16:   hdr_byte = total[15:8];
            6'd17:   hdr_byte = total[7:0];
            6'd22:   hdr_byte = cfg.hop_limit;
            6'd23:   hdr_byte = cfg.protocol_number;
            6'd24:   hdr_byte = ck_reg[15:8];
            6'd25:   hdr_byte = ck_reg[7:0];
            6'd26:   hdr_byte = cfg.source_ip[31:24];
            6'd27:   hdr_byte = cfg.source_ip[23:16];
            6'd28:   hdr_byte = cfg.source_ip[15:8];
            6'd29:   hdr_byte = cfg.source_ip[7:0];
            6'd30:   hdr_byte = cfg.dest_ip[31:24];
            6'd31:   hdr_byte = cfg.dest_ip[23:16];
            6'd32:   hdr_byte = cfg.dest_ip[15:8];
            6'd33:   hdr_byte = cfg.dest_ip[7:0];
            default: hdr_byte = 8'h00;
        endcase
    end

endmodule

`default_nettype wire

FILE: tb/sv/tb_ipv4_ethernet_encapsulator_top.sv
`timescale 1ns / 1ps

module tb_ipv4_ethernet_encapsulator_top;
    import ipv4enc_pkg::*;

    localparam int CYCLE_LIMIT = 5_000_000;
    localparam int RANDOM_ITEMS = 450;
    localparam int RANDOM_PHASES = 4;
    // indexes past the last register; writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed
    {
        logic [7:0] out_byte;
        logic       header_byte;
        logic       frame_end;
        logic       run_end;
    } frame_byte_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata = '0;  // payload_length[10:0], data_byte[18:11]
    logic                  s_axis_tuser = 1'b0; // op
    logic                  s_axis_tlast = 1'b0; // end_of_payload
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [7:0]            m_axis_tdata;        // out_byte[7:0]
    logic [1:0]            m_axis_tuser;        // header_byte[0], run_end[1]
    logic                  m_axis_tlast;        // frame_end

    cfg_t        hdr_cfg;
    logic        open_frame;
    frame_byte_t expected_bytes[$];
    int          mismatch_count = 0;
    int          items_sent = 0;
    int          cycle_count = 0;
    bit          no_gaps = 1'b0;

    ipv4_ethernet_encapsulator_top u_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("ipv4_ethernet_encapsulator_top: mismatch");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t: %s got %0h want %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // Works out the frame bytes that one accepted item produces.
    task automatic encapsulate_item(input op_t op, input logic [LEN_W-1:0] len_in,
                                    input logic [7:0] data, input logic eop);
        logic [7:0]       hdr [HDR_LEN];
        logic [LEN_W-1:0] len;
        logic [15:0]      total_len;
        logic [31:0]      csum;
        logic [15:0]      ck;
        frame_byte_t      fb;
        logic             last;
        if (op == OP_START)
        begin
            len = (len_in > LEN_MAX) ? LEN_MAX : len_in;
            total_len = 16'(len) + 16'(IP_HDR_LEN);
            for (int i = 0; i < HDR_LEN; i++)
                hdr[i] = 8'h00;
            for (int i = 0; i < 6; i++)
            begin
                hdr[i]     = hdr_cfg.dest_mac[8*(5-i) +: 8];
                hdr[6 + i] = hdr_cfg.source_mac[8*(5-i) +: 8];
            end
            hdr[12] = ETHTYPE_HI;
            hdr[13] = ETHTYPE_LO;
            hdr[14] = VER_IHL;
            hdr[16] = total_len[15:8];
            hdr[17] = total_len[7:0];
            hdr[22] = hdr_cfg.hop_limit;
            hdr[23] = hdr_cfg.protocol_number;
            for (int i = 0; i < 4; i++)
            begin
                hdr[26 + i] = hdr_cfg.source_ip[8*(3-i) +: 8];
                hdr[30 + i] = hdr_cfg.dest_ip[8*(3-i) +: 8];
            end
            csum = 32'd0;
            for (int i = 14; i < HDR_LEN; i += 2)
                csum = csum + 32'({hdr[i], hdr[i + 1]});
            while (csum[31:16] != 16'd0)
                csum = 32'(csum[15:0]) + 32'(csum[31:16]);
            ck = ~csum[15:0];
            hdr[24] = ck[15:8];
            hdr[25] = ck[7:0];
            for (int i = 0; i < HDR_LEN; i++)
            begin
                last = (i == HDR_LEN - 1);
                fb.out_byte    = hdr[i];
                fb.header_byte = 1'b1;
                fb.frame_end   = (len == '0) && last;
                fb.run_end     = last;
                expected_bytes.push_back(fb);
            end
            open_frame = (len != '0);
        end
        else if (open_frame)
        begin
            fb.out_byte    = data;
            fb.header_byte = 1'b0;
            fb.frame_end   = eop;
            fb.run_end     = 1'b1;
            expected_bytes.push_back(fb);
            if (eop)
                open_frame = 1'b0;
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Called at a rising edge; returns at the edge where the item was taken.
    task automatic send_item(input op_t op, input logic [LEN_W-1:0] len,
                             input logic [7:0] data, input logic eop);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {5'd0, data, len};
        s_axis_tlast  <= eop;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        encapsulate_item(op, len, data, eop);
        items_sent++;
    endtask

    task automatic send_start(input logic [LEN_W-1:0] len);
        send_item(OP_START, len, 8'($urandom()), 1'($urandom()));
    endtask

    task automatic send_byte(input logic [7:0] data, input logic eop);
        send_item(OP_PAYLOAD, LEN_W'($urandom()), data, eop);
    endtask

    // Orphan payload items give no output, so leave time for them to drain.
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_DEST_MAC:   hdr_cfg.dest_mac        = data[47:0];
            REG_SOURCE_MAC: hdr_cfg.source_mac      = data[47:0];
            REG_SOURCE_IP:  hdr_cfg.source_ip       = data[31:0];
            REG_DEST_IP:    hdr_cfg.dest_ip         = data[31:0];
            REG_HOP_LIMIT:  hdr_cfg.hop_limit       = data[7:0];
            REG_PROTOCOL:   hdr_cfg.protocol_number = data[7:0];
            default:        ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_all(input cfg_t v);
        write_reg(REG_DEST_MAC, CFG_DATA_W'(v.dest_mac));
        write_reg(REG_SOURCE_MAC, CFG_DATA_W'(v.source_mac));
        write_reg(REG_SOURCE_IP, CFG_DATA_W'(v.source_ip));
        write_reg(REG_DEST_IP, CFG_DATA_W'(v.dest_ip));
        write_reg(REG_HOP_LIMIT, CFG_DATA_W'(v.hop_limit));
        write_reg(REG_PROTOCOL, CFG_DATA_W'(v.protocol_number));
    endtask

    function automatic cfg_t random_cfg();
        cfg_t v;
        v.dest_mac        = 48'({$urandom(), $urandom()});
        v.source_mac      = 48'({$urandom(), $urandom()});
        v.source_ip       = $urandom();
        v.dest_ip         = $urandom();
        v.hop_limit       = 8'($urandom());
        v.protocol_number = 8'($urandom());
        return v;
    endfunction

    // Short frames on the reset defaults, zero length and orphan bytes.
    task automatic test_defaults();
        send_start(11'd0);
        send_byte(8'h00, 1'b1);
        send_start(11'd1);
        send_byte(8'hff, 1'b1);
        send_byte(8'h3c, 1'b0);
        send_start(11'd3);
        send_byte(8'h00, 1'b0);
        send_byte(8'ha5, 1'b0);
        send_byte(8'h5a, 1'b1);
    endtask

    // Saturation of long lengths and abandoned frames.
    task automatic test_length_limits();
        send_start(11'd1472);
        send_byte(8'h81, 1'b0);
        send_start(11'd1473);
        send_start(11'd2047);
        send_byte(8'h7e, 1'b1);
        send_start(11'h555);
        send_byte(8'h55, 1'b0);
        send_start(11'h2aa);
        send_byte(8'haa, 1'b1);
        send_byte(8'hc3, 1'b1);
    endtask

    task automatic test_config_extremes();
        cfg_t v;
        wait_idle();
        v = '0;
        write_all(v);
        send_start(11'd2);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b1);
        wait_idle();
        v = '1;
        write_all(v);
        send_start(11'd1472);
        send_byte(8'hff, 1'b1);
        wait_idle();
        write_reg(REG_SPARE_LO, 48'({$urandom(), $urandom()}));
        write_reg(REG_SPARE_HI, 48'({$urandom(), $urandom()}));
        send_start(11'd0);
    endtask

    task automatic test_random_traffic();
        int kind;
        int nbytes;
        logic [LEN_W-1:0] len;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            wait_idle();
            write_all(random_cfg());
            if ($urandom_range(0, 1) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE_LO : REG_SPARE_HI,
                          48'({$urandom(), $urandom()}));
            while (items_sent < (phase + 1) * RANDOM_ITEMS / RANDOM_PHASES)
            begin
                no_gaps = ($urandom_range(0, 7) == 0);
                kind = $urandom_range(0, 99);
                if (kind < 10)
                    len = LEN_W'($urandom_range(0, 2047));
                else
                    len = LEN_W'($urandom_range(0, 24));
                if (kind < 80)
                begin
                    // well-formed frame: byte count follows length up to 24, else random from 1 to 24
                    send_start(len);
                    nbytes = (len > 24) ? $urandom_range(1, 24) : int'(len);
                    for (int i = 0; i < nbytes; i++)
                        send_byte(8'($urandom()), i == nbytes - 1);
                end
                else if (kind < 90)
                begin
                    // truncated frame, left open for the next start
                    send_start(len);
                    nbytes = $urandom_range(0, 6);
                    for (int i = 0; i < nbytes; i++)
                        send_byte(8'($urandom()), 1'b0);
                end
                else
                begin
                    nbytes = $urandom_range(1, 3);
                    for (int i = 0; i < nbytes; i++)
                        send_byte(8'($urandom()), 1'($urandom()));
                end
            end
        end
        no_gaps = 1'b0;
    endtask

    // Result check and output stall pattern.
    int stall_left = 0;
    always @(posedge clk)
    begin : rx_check
        frame_byte_t want;
        int r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_bytes.size() == 0)
                report_mismatch("unexpected item, byte", m_axis_tdata, 8'h00);
            else
            begin
                want = expected_bytes.pop_front();
                if (m_axis_tdata !== want.out_byte)
                    report_mismatch("out_byte", m_axis_tdata, want.out_byte);
                if (m_axis_tuser[0] !== want.header_byte)
                    report_mismatch("header_byte", 8'(m_axis_tuser[0]), 8'(want.header_byte));
                if (m_axis_tuser[1] !== want.run_end)
                    report_mismatch("run_end", 8'(m_axis_tuser[1]), 8'(want.run_end));
                if (m_axis_tlast !== want.frame_end)
                    report_mismatch("frame_end", 8'(m_axis_tlast), 8'(want.frame_end));
            end
        end
        r = $urandom_range(0, 99);
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (no_gaps || r >= 25)
            m_axis_tready <= 1'b1;
        else
        begin
            m_axis_tready <= 1'b0;
            stall_left <= (r < 2) ? $urandom_range(8, 40) : $urandom_range(0, 2);
        end
    end

    initial
    begin
        hdr_cfg.dest_mac        = DEST_MAC_RST;
        hdr_cfg.source_mac      = SOURCE_MAC_RST;
        hdr_cfg.source_ip       = SOURCE_IP_RST;
        hdr_cfg.dest_ip         = DEST_IP_RST;
        hdr_cfg.hop_limit       = HOP_LIMIT_RST;
        hdr_cfg.protocol_number = PROTOCOL_RST;
        open_frame = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_defaults();
        test_length_limits();
        test_config_extremes();
        test_random_traffic();

        s_axis_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && expected_bytes.size() == 0)
            $display("ipv4_ethernet_encapsulator_top: match");
        else
            $display("ipv4_ethernet_encapsulator_top: mismatch");
        $finish;
    end

endmodule
